// ===== src/pwpc_pkg.sv =====
// Shared types and constants for the pulse width and period capture block.
package pwpc_pkg;

    localparam int CHANNELS   = 4;
    localparam int TIME_BITS  = 32;
    localparam int CH_IDX_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int OUT_BITS   = 32;
    localparam int CH_BITS    = 2;
    localparam int EXPIRY_SHL = 2;

    typedef logic [TIME_BITS-1:0] time_t;
    typedef logic [CH_IDX_W-1:0]  ch_idx_t;

    typedef enum logic [1:0] {
        OP_RISE  = 2'd0,
        OP_FALL  = 2'd1,
        OP_CRANK = 2'd2,
        OP_QUERY = 2'd3
    } op_t;

endpackage

// ===== src/pulse_width_period_capture.sv =====
// Top level: per-channel pulse width, period and crank offset capture.
// A result beat is formed from the input register and offered from the result register;
// the beat waits in the input register while the result channel stalls.
// Throughput: one beat per cycle while m_ready does not stall the result register; the
// selected channel's state is read, modified and written back between the two registers.
// Reset (aresetn low, synchronous): clears all channel and crank state and drops both valids.
module pulse_width_period_capture
    import pwpc_pkg::*;
(
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [1:0]                 s_operation,
    input  logic [CH_BITS-1:0]         s_channel,
    input  logic                       s_first_tooth,
    input  logic [31:0]                s_timestamp,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [OUT_BITS-1:0]        m_low_width,
    output logic [OUT_BITS-1:0]        m_high_width,
    output logic [OUT_BITS-1:0]        m_signal_period,
    output logic signed [OUT_BITS-1:0] m_crank_offset,
    output logic [OUT_BITS-1:0]        m_event_count
);

    logic                 in_valid_reg;
    op_t                  op_reg;
    logic [CH_BITS-1:0]   ch_reg;
    logic                 first_reg;
    time_t                now_reg;

    time_t                rise_time_reg     [CHANNELS];
    time_t                fall_time_reg     [CHANNELS];
    time_t                last_activity_reg [CHANNELS];
    time_t                low_width_reg     [CHANNELS];
    time_t                high_width_reg    [CHANNELS];
    time_t                period_reg        [CHANNELS];
    time_t                offset_reg        [CHANNELS];
    logic [OUT_BITS-1:0]  edge_count_reg    [CHANNELS];
    time_t                crank_period_reg;
    time_t                crank_start_reg;

    logic                 m_valid_reg;
    logic [OUT_BITS-1:0]  m_low_width_reg;
    logic [OUT_BITS-1:0]  m_high_width_reg;
    logic [OUT_BITS-1:0]  m_signal_period_reg;
    logic [OUT_BITS-1:0]  m_crank_offset_reg;
    logic [OUT_BITS-1:0]  m_event_count_reg;

    logic                 advance;
    logic                 ch_ok;
    ch_idx_t              idx;

    time_t                rise_next;
    time_t                fall_next;
    time_t                act_next;
    time_t                low_next;
    time_t                high_next;
    time_t                period_next;
    time_t                offset_next;
    logic [OUT_BITS-1:0]  count_next;
    time_t                crank_period_next;
    time_t                crank_start_next;

    time_t                off_raw;
    time_t                off_wrap;
    time_t                half_sum;
    time_t                half_period;
    logic                 expired;

    assign advance = in_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    assign ch_ok = (int'(ch_reg) < CHANNELS);
    assign idx   = ch_ok ? CH_IDX_W'(ch_reg) : '0;

    // signed half of the crank period, truncated toward zero
    assign half_sum    = crank_period_reg + time_t'(crank_period_reg[TIME_BITS-1]);
    assign half_period = time_t'($signed(half_sum) >>> 1);
    assign off_raw     = now_reg - crank_start_reg;
    assign off_wrap    = off_raw - crank_period_reg;

    always_comb begin
        rise_next         = rise_time_reg[idx];
        fall_next         = fall_time_reg[idx];
        act_next          = last_activity_reg[idx];
        low_next          = low_width_reg[idx];
        high_next         = high_width_reg[idx];
        period_next       = period_reg[idx];
        offset_next       = offset_reg[idx];
        count_next        = edge_count_reg[idx];
        crank_period_next = crank_period_reg;
        crank_start_next  = crank_start_reg;
        unique case (op_reg)
            OP_CRANK: begin
                if (first_reg) begin
                    crank_period_next = now_reg - crank_start_reg;
                    crank_start_next  = now_reg;
                end
            end
            OP_RISE: begin
                if (ch_ok) begin
                    count_next  = edge_count_reg[idx] + OUT_BITS'(1);
                    act_next    = now_reg;
                    low_next    = now_reg - fall_time_reg[idx];
                    period_next = now_reg - rise_time_reg[idx];
                    rise_next   = now_reg;
                end
            end
            OP_FALL: begin
                if (ch_ok) begin
                    count_next  = edge_count_reg[idx] + OUT_BITS'(1);
                    act_next    = now_reg;
                    high_next   = now_reg - rise_time_reg[idx];
                    fall_next   = now_reg;
                    offset_next = ($signed(off_raw) > $signed(half_period)) ? off_wrap : off_raw;
                end
            end
            OP_QUERY: begin
            end
            default: begin
            end
        endcase
    end

    assign expired = (now_reg - act_next) > (crank_period_next << EXPIRY_SHL);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
        if (s_valid && s_ready) begin
            op_reg    <= op_t'(s_operation);
            ch_reg    <= s_channel;
            first_reg <= s_first_tooth;
            now_reg   <= time_t'(s_timestamp);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < CHANNELS; i++) begin
                rise_time_reg[i]     <= '0;
                fall_time_reg[i]     <= '0;
                last_activity_reg[i] <= '0;
                low_width_reg[i]     <= '0;
                high_width_reg[i]    <= '0;
                period_reg[i]        <= '0;
                offset_reg[i]        <= '0;
                edge_count_reg[i]    <= '0;
            end
            crank_period_reg <= '0;
            crank_start_reg  <= '0;
        end else if (advance) begin
            crank_period_reg <= crank_period_next;
            crank_start_reg  <= crank_start_next;
            if (ch_ok) begin
                rise_time_reg[idx]     <= rise_next;
                fall_time_reg[idx]     <= fall_next;
                last_activity_reg[idx] <= act_next;
                low_width_reg[idx]     <= low_next;
                high_width_reg[idx]    <= high_next;
                period_reg[idx]        <= period_next;
                offset_reg[idx]        <= offset_next;
                edge_count_reg[idx]    <= count_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
        if (advance) begin
            m_low_width_reg     <= ch_ok ? OUT_BITS'(low_next) : '0;
            m_high_width_reg    <= (ch_ok && !expired) ? OUT_BITS'(high_next) : '0;
            m_signal_period_reg <= ch_ok ? OUT_BITS'(period_next) : '0;
            m_crank_offset_reg  <= ch_ok ? OUT_BITS'(offset_next) : '0;
            m_event_count_reg   <= ch_ok ? count_next : '0;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_low_width     = m_low_width_reg;
    assign m_high_width    = m_high_width_reg;
    assign m_signal_period = m_signal_period_reg;
    assign m_crank_offset  = $signed(m_crank_offset_reg);
    assign m_event_count   = m_event_count_reg;

    a_advance_offers_beat: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> m_valid)
        else $error("processed beat not offered on result channel");

    a_edge_counts: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && ch_ok && (op_reg == OP_RISE || op_reg == OP_FALL)
        |=> m_event_count == $past(edge_count_reg[idx]) + OUT_BITS'(1))
        else $error("edge beat did not advance the channel edge count");

    a_crank_start: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && op_reg == OP_CRANK && first_reg |=> crank_start_reg == $past(now_reg))
        else $error("first crank tooth did not set crank start");

    a_rise_period: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && ch_ok && op_reg == OP_RISE
        |=> m_signal_period == OUT_BITS'($past(now_reg - rise_time_reg[idx])))
        else $error("rising edge period mismatch");

endmodule

// ===== dv/tb.sv =====
// Testbench for pulse_width_period_capture: random and directed capture events checked against a predictor.
`timescale 1ns / 1ps

module tb;
    import pwpc_pkg::*;

    localparam int RANDOM_ITEMS = 1650;
    localparam int CYCLE_LIMIT  = 250000;
    localparam int TAIL_ITEMS   = 250;
    localparam int HOLD_AT      = 1500;
    localparam int HOLD_CYCLES  = 240;

    typedef struct {
        op_t                operation;
        logic [CH_BITS-1:0] channel;
        logic               first_tooth;
        time_t              timestamp;
    } capture_event_t;

    typedef struct {
        logic [OUT_BITS-1:0]        low_width;
        logic [OUT_BITS-1:0]        high_width;
        logic [OUT_BITS-1:0]        signal_period;
        logic signed [OUT_BITS-1:0] crank_offset;
        logic [OUT_BITS-1:0]        event_count;
    } capture_result_t;

    logic                       aclk = 1'b0;
    logic                       aresetn = 1'b0;
    logic                       s_valid = 1'b0;
    logic                       s_ready;
    logic [1:0]                 s_operation = OP_QUERY;
    logic [CH_BITS-1:0]         s_channel = '0;
    logic                       s_first_tooth = 1'b0;
    logic [31:0]                s_timestamp = '0;
    logic                       m_valid;
    logic                       m_ready = 1'b0;
    logic [OUT_BITS-1:0]        m_low_width;
    logic [OUT_BITS-1:0]        m_high_width;
    logic [OUT_BITS-1:0]        m_signal_period;
    logic signed [OUT_BITS-1:0] m_crank_offset;
    logic [OUT_BITS-1:0]        m_event_count;

    capture_event_t  pending_events[$];
    capture_result_t predicted_readings[$];
    capture_event_t  on_wire;

    time_t rise_at[CHANNELS];
    time_t fall_at[CHANNELS];
    time_t active_at[CHANNELS];
    time_t low_w[CHANNELS];
    time_t high_w[CHANNELS];
    time_t period_w[CHANNELS];
    time_t offset_w[CHANNELS];
    logic [OUT_BITS-1:0] edges[CHANNELS];
    time_t crank_len = '0;
    time_t crank_t0 = '0;

    int  total_items = 0;
    int  accepted_items = 0;
    int  results_seen = 0;
    int  mismatches = 0;
    int  cycles = 0;
    int  src_gap = 0;
    int  sink_gap = 0;
    int  sink_cycles = 0;
    int  hold_left = 0;
    bit  quiet_tail;

    assign quiet_tail = (accepted_items + TAIL_ITEMS >= total_items);

    pulse_width_period_capture i_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_operation    (s_operation),
        .s_channel      (s_channel),
        .s_first_tooth  (s_first_tooth),
        .s_timestamp    (s_timestamp),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_low_width    (m_low_width),
        .m_high_width   (m_high_width),
        .m_signal_period(m_signal_period),
        .m_crank_offset (m_crank_offset),
        .m_event_count  (m_event_count)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    initial begin
        for (int i = 0; i < CHANNELS; i++) begin
            rise_at[i] = '0;
            fall_at[i] = '0;
            active_at[i] = '0;
            low_w[i] = '0;
            high_w[i] = '0;
            period_w[i] = '0;
            offset_w[i] = '0;
            edges[i] = '0;
        end
    end

    function automatic capture_result_t measure_event(capture_event_t ev);
        capture_result_t r;
        time_t           off;
        time_t           half;
        time_t           idle;
        time_t           reach;
        bit              known;
        int unsigned     c;
        known = (ev.channel < CHANNELS);
        c = known ? ev.channel : 0;
        case (ev.operation)
            OP_CRANK: begin
                if (ev.first_tooth) begin
                    crank_len = ev.timestamp - crank_t0;
                    crank_t0 = ev.timestamp;
                end
            end
            OP_RISE: begin
                if (known) begin
                    edges[c] = edges[c] + 1'b1;
                    active_at[c] = ev.timestamp;
                    low_w[c] = ev.timestamp - fall_at[c];
                    period_w[c] = ev.timestamp - rise_at[c];
                    rise_at[c] = ev.timestamp;
                end
            end
            OP_FALL: begin
                if (known) begin
                    edges[c] = edges[c] + 1'b1;
                    active_at[c] = ev.timestamp;
                    high_w[c] = ev.timestamp - rise_at[c];
                    fall_at[c] = ev.timestamp;
                    off = ev.timestamp - crank_t0;
                    half = $signed(crank_len) / 2;
                    if ($signed(off) > $signed(half)) begin
                        off = off - crank_len;
                    end
                    offset_w[c] = off;
                end
            end
            default: begin
            end
        endcase
        r = '{default: '0};
        if (known) begin
            idle = ev.timestamp - active_at[c];
            reach = crank_len << EXPIRY_SHL;
            r.low_width = low_w[c];
            r.high_width = (idle > reach) ? '0 : high_w[c];
            r.signal_period = period_w[c];
            r.crank_offset = offset_w[c];
            r.event_count = edges[c];
        end
        return r;
    endfunction

    task automatic add_event(op_t op, int ch, bit first, time_t ts);
        capture_event_t ev;
        ev.operation = op;
        ev.channel = ch[CH_BITS-1:0];
        ev.first_tooth = first;
        ev.timestamp = ts;
        pending_events.push_back(ev);
    endtask

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        if (mismatches < 200) begin
            $display("beat %0d: %s got %h want %h", results_seen, what, got, want);
        end
        mismatches++;
    endtask

    initial begin : stimulus
        time_t now;
        int    tooth_wait;
        int    tooth_gap;
        int    teeth_rev;
        int    tooth_idx;
        int    hot_ch;
        int    ch;
        int    roll;
        bit    level[CHANNELS];

        add_event(OP_QUERY, 0, 1'b0, 32'h0000_0000);
        add_event(OP_RISE,  0, 1'b0, 32'h0000_0064);
        add_event(OP_FALL,  0, 1'b0, 32'h0000_0096);
        add_event(OP_QUERY, 0, 1'b0, 32'h0000_0096);
        add_event(OP_QUERY, 0, 1'b0, 32'h0000_0097);
        add_event(OP_CRANK, 1, 1'b1, 32'h0000_03E8);
        add_event(OP_CRANK, 1, 1'b0, 32'h0000_04B0);
        add_event(OP_FALL,  1, 1'b0, 32'h0000_0578);
        add_event(OP_FALL,  1, 1'b0, 32'h0000_05DC);
        add_event(OP_FALL,  1, 1'b1, 32'h0000_0640);
        add_event(OP_RISE,  2, 1'b1, 32'hFFFF_FFF0);
        add_event(OP_FALL,  2, 1'b0, 32'h0000_0010);
        add_event(OP_RISE,  2, 1'b0, 32'hFFFF_FFFF);
        add_event(OP_QUERY, 2, 1'b1, 32'h0000_1000);
        add_event(OP_QUERY, 2, 1'b0, 32'h0000_0F9F);
        add_event(OP_CRANK, 3, 1'b1, 32'h8000_2000);
        add_event(OP_FALL,  3, 1'b0, 32'h8000_2010);
        add_event(OP_RISE,  3, 1'b0, 32'hFFFF_FFFF);
        add_event(OP_FALL,  3, 1'b1, 32'h0000_0000);
        add_event(OP_CRANK, 0, 1'b1, 32'h8000_2000);
        add_event(OP_FALL,  0, 1'b0, 32'h8000_1FFF);
        add_event(OP_CRANK, 1, 1'b1, 32'h0000_2000);
        add_event(OP_FALL,  1, 1'b0, 32'h0000_2001);
        add_event(OP_QUERY, 3, 1'b0, 32'hFFFF_FFFF);

        now = 32'h0000_3000;
        tooth_gap = 40;
        teeth_rev = 6;
        tooth_idx = 0;
        tooth_wait = 0;
        hot_ch = 0;
        for (int i = 0; i < CHANNELS; i++) begin
            level[i] = 1'b0;
        end
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            roll = $urandom_range(0, 99);
            if (roll < 10) begin
                add_event(op_t'(2'($urandom_range(0, 3))), $urandom_range(0, CHANNELS - 1),
                          1'($urandom_range(0, 1)), $urandom);
            end else if (roll < 13) begin
                now = now + $urandom;
                add_event(OP_QUERY, $urandom_range(0, CHANNELS - 1),
                          1'($urandom_range(0, 1)), now);
            end else begin
                if ($urandom_range(0, 99) == 0) begin
                    tooth_gap = $urandom_range(5, 200);
                    teeth_rev = $urandom_range(1, 12);
                end
                if ($urandom_range(0, 49) == 0) begin
                    hot_ch = $urandom_range(0, CHANNELS - 1);
                end
                roll = $urandom_range(1, 60);
                now = now + roll;
                tooth_wait -= roll;
                if (tooth_wait <= 0) begin
                    add_event(OP_CRANK, $urandom_range(0, CHANNELS - 1), tooth_idx == 0, now);
                    tooth_idx = (tooth_idx + 1) % teeth_rev;
                    tooth_wait = tooth_gap + $urandom_range(0, 4);
                end else begin
                    ch = ($urandom_range(0, 9) < 7) ? hot_ch : $urandom_range(0, CHANNELS - 1);
                    roll = $urandom_range(0, 9);
                    if (roll == 0) begin
                        add_event(OP_QUERY, ch, 1'b0, now);
                    end else if (roll == 1) begin
                        // repeat the last edge kind
                        add_event(level[ch] ? OP_RISE : OP_FALL, ch, 1'b0, now);
                    end else begin
                        level[ch] = !level[ch];
                        add_event(level[ch] ? OP_RISE : OP_FALL, ch, 1'b0, now);
                    end
                end
            end
        end
        total_items = pending_events.size();

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        do @(posedge aclk);
        while (accepted_items != total_items || predicted_readings.size() != 0);
        repeat (8) @(posedge aclk);
        if (mismatches == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                predicted_readings.push_back(measure_event(on_wire));
                accepted_items++;
            end
            if (!s_valid || s_ready) begin
                if (src_gap > 0) begin
                    src_gap--;
                    s_valid <= 1'b0;
                end else if (pending_events.size() != 0 && !quiet_tail
                             && $urandom_range(0, 9) == 0) begin
                    src_gap = $urandom_range(0, 12);
                    s_valid <= 1'b0;
                end else if (pending_events.size() != 0) begin
                    on_wire = pending_events.pop_front();
                    s_operation <= on_wire.operation;
                    s_channel <= on_wire.channel;
                    s_first_tooth <= on_wire.first_tooth;
                    s_timestamp <= on_wire.timestamp;
                    s_valid <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            sink_cycles++;
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (sink_cycles == HOLD_AT) begin
                hold_left = HOLD_CYCLES - 1;
                m_ready <= 1'b0;
            end else if (sink_gap > 0) begin
                sink_gap--;
                m_ready <= 1'b0;
            end else if (!quiet_tail && $urandom_range(0, 7) == 0) begin
                sink_gap = $urandom_range(0, 12);
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin : result_check
        capture_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (predicted_readings.size() == 0) begin
                report_mismatch("unexpected beat, low_width", m_low_width, '0);
            end else begin
                want = predicted_readings.pop_front();
                if (m_low_width !== want.low_width)
                    report_mismatch("low_width", m_low_width, want.low_width);
                if (m_high_width !== want.high_width)
                    report_mismatch("high_width", m_high_width, want.high_width);
                if (m_signal_period !== want.signal_period)
                    report_mismatch("signal_period", m_signal_period, want.signal_period);
                if (m_crank_offset !== want.crank_offset)
                    report_mismatch("crank_offset", m_crank_offset, want.crank_offset);
                if (m_event_count !== want.event_count)
                    report_mismatch("event_count", m_event_count, want.event_count);
            end
            results_seen++;
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

endmodule

// ===== files.f =====
src/pwpc_pkg.sv
src/pulse_width_period_capture.sv
dv/tb.sv
